FILE: src/line_editor_with_echo_unit_assert.svh
// ----------------------------------------------------------------------------
// Line editor assertion macros
// Shared property forms for the line editor checker.
// ----------------------------------------------------------------------------
`ifndef LINE_EDITOR_WITH_ECHO_UNIT_ASSERT_SVH
`define LINE_EDITOR_WITH_ECHO_UNIT_ASSERT_SVH

// same-cycle implication, disabled in reset
`define LEU_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define LEU_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/leu_pkg.sv
// ----------------------------------------------------------------------------
// Line editor package
// Constants, key codes and result kinds shared by the line editor files.
// ----------------------------------------------------------------------------
package leu_pkg;

  // default sizes
  localparam int unsigned LEU_BUF_DEPTH   = 256;
  localparam int unsigned LEU_TAB_WIDTH   = 4;
  // most results one item may cause
  localparam int unsigned LEU_MAX_RESULTS = 5;

  // item kinds on the input channel
  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // key codes (7-bit)
  localparam logic [6:0] KEY_BS     = 7'h08;
  localparam logic [6:0] KEY_TAB    = 7'h09;
  localparam logic [6:0] KEY_LF     = 7'h0A;
  localparam logic [6:0] KEY_CR     = 7'h0D;
  localparam logic [6:0] CHAR_SPACE = 7'h20;

  // result kinds
  typedef enum logic [1:0] {
    OUT_ECHO = 2'd0,
    OUT_DONE = 2'd1,
    OUT_READ = 2'd2
  } out_kind_e;

endpackage

FILE: src/leu_ram.sv
// ----------------------------------------------------------------------------
// Line editor RAM
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module leu_ram #(
  parameter int unsigned WIDTH = 7,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/line_editor_with_echo_unit.sv
// ----------------------------------------------------------------------------
// Line editor with echo
// Terminal line discipline: edits a line in a character store, echoes keys,
// reports completed lines and reads back stored characters.
// ----------------------------------------------------------------------------
// An input beat is taken into a job register; each following cycle in which
// the result register is free, the job produces one result beat. A read, a
// backspace or a plain key that leaves the line open gives at most one beat,
// so such items stream at one per cycle unless the output stalls; CR/LF and
// any key that ends the line give an echo, then a completion; a tab gives
// one beat per space plus a completion if the line fills, at most five. The
// rate is set by the single result register and the one write port of the
// character store. A new item is taken in the cycle the previous job issues
// its last beat. Reads see every earlier write. No clearing pass after reset.
module line_editor_with_echo_unit import leu_pkg::*; #(
  parameter int unsigned BUF_DEPTH = LEU_BUF_DEPTH,
  parameter int unsigned TAB_WIDTH = LEU_TAB_WIDTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [8:0] max_len_i,
  // input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       kind_i,
  input  logic [7:0] keycode_i,
  input  logic [7:0] read_index_i,
  // output channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] out_kind_o,
  output logic [6:0] out_char_o,
  output logic [7:0] line_length_o,
  output logic       last_o
);

  localparam int unsigned AW  = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int unsigned CAP = (BUF_DEPTH < 256) ? BUF_DEPTH : 256;
  localparam int unsigned TAB_SPACES =
    (TAB_WIDTH < LEU_MAX_RESULTS - 1) ? TAB_WIDTH : LEU_MAX_RESULTS - 1;
  localparam int unsigned CW  = $clog2(TAB_SPACES + 1);

  // limit register, clamped on write
  logic [8:0] n_clamp;
  logic [7:0] lim_d, lim_q;

  always_comb begin
    n_clamp = max_len_i;
    if (n_clamp > 9'(CAP)) begin
      n_clamp = 9'(CAP);
    end
    if (n_clamp < 9'd2) begin
      n_clamp = 9'd2;
    end
    lim_d = 8'(n_clamp - 9'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= 8'(CAP - 1);
    end else if (cfg_we_i) begin
      lim_q <= lim_d;
    end
  end

  // job and line state
  logic          job_valid_q;
  logic          job_kind_q;
  logic [6:0]    job_char_q;
  logic [CW-1:0] cnt_q, cnt_nx;
  logic          comp_q;
  logic [7:0]    wp_q, wp_nx;

  // read path
  logic          rd_oob_q, byp_q;
  logic [6:0]    byp_data_q, ram_rdata, rd_char;

  // result register
  logic          out_valid_q;
  logic [1:0]    out_kind_q;
  logic [6:0]    out_char_q;
  logic [7:0]    line_length_q;
  logic          last_q;

  // beat decode
  logic          emit, need_comp, more, blast, wr_en;
  out_kind_e     bkind;
  logic [6:0]    bchar, wr_data;
  logic [7:0]    blen;
  logic          out_free, step, in_fire, ram_we;
  logic [AW-1:0] waddr, raddr;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = job_valid_q && out_free;
  assign in_ready_o = !job_valid_q || (step && blast);
  assign in_fire    = in_valid_i && in_ready_o;

  assign rd_char = rd_oob_q ? 7'd0 : (byp_q ? byp_data_q : ram_rdata);

  // one result beat of the current job
  always_comb begin
    emit      = 1'b0;
    bkind     = OUT_ECHO;
    bchar     = 7'd0;
    blen      = 8'd0;
    need_comp = 1'b0;
    more      = 1'b0;
    wr_en     = 1'b0;
    wr_data   = 7'd0;
    wp_nx     = wp_q;
    cnt_nx    = cnt_q;
    if (comp_q) begin
      emit  = 1'b1;
      bkind = OUT_DONE;
      blen  = wp_q;
      wp_nx = 8'd0;
    end else if (job_kind_q == KIND_READ) begin
      emit  = 1'b1;
      bkind = OUT_READ;
      bchar = rd_char;
    end else begin
      case (job_char_q) inside
        KEY_BS: begin
          // nothing at all at the start of the line
          if (wp_q != 8'd0) begin
            emit      = 1'b1;
            bchar     = KEY_BS;
            wp_nx     = wp_q - 8'd1;
            need_comp = (wp_nx >= lim_q);
          end
        end
        KEY_TAB: begin
          if (wp_q < lim_q) begin
            emit      = 1'b1;
            bchar     = CHAR_SPACE;
            wr_en     = 1'b1;
            wr_data   = CHAR_SPACE;
            wp_nx     = wp_q + 8'd1;
            cnt_nx    = cnt_q - CW'(1);
            need_comp = (wp_nx >= lim_q);
            more      = !need_comp && (cnt_q > CW'(1));
          end else begin
            // no room left: complete at once
            emit  = 1'b1;
            bkind = OUT_DONE;
            blen  = wp_q;
            wp_nx = 8'd0;
          end
        end
        KEY_LF, KEY_CR: begin
          emit      = 1'b1;
          bchar     = KEY_LF;
          need_comp = 1'b1;
        end
        default: begin
          emit      = 1'b1;
          bchar     = job_char_q;
          wr_en     = 1'b1;
          wr_data   = job_char_q;
          wp_nx     = wp_q + 8'd1;
          need_comp = (wp_nx >= lim_q);
        end
      endcase
    end
    blast = !need_comp && !more;
  end

  // job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      comp_q      <= 1'b0;
      cnt_q       <= '0;
      wp_q        <= 8'd0;
    end else begin
      if (step) begin
        wp_q   <= wp_nx;
        cnt_q  <= cnt_nx;
        comp_q <= need_comp;
      end
      if (in_fire) begin
        job_valid_q <= 1'b1;
        comp_q      <= 1'b0;
        cnt_q       <= CW'(TAB_SPACES);
      end else if (step && blast) begin
        job_valid_q <= 1'b0;
      end
    end
  end

  // job payload
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      job_kind_q <= kind_i;
      job_char_q <= keycode_i[6:0];
    end
  end

  // character store
  assign ram_we = step && wr_en && (32'(wp_q) < BUF_DEPTH);
  assign waddr  = AW'(wp_q);
  assign raddr  = AW'(read_index_i);

  leu_ram #(
    .WIDTH (7),
    .DEPTH (BUF_DEPTH)
  ) u_leu_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // read side flags: out of range, and forwarding of a same-cycle write
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_oob_q   <= (32'(read_index_i) >= BUF_DEPTH);
      byp_q      <= ram_we && (waddr == raddr);
      byp_data_q <= wr_data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && emit) begin
      out_kind_q    <= bkind;
      out_char_q    <= bchar;
      line_length_q <= blen;
      last_q        <= blast;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_kind_o    = out_kind_q;
  assign out_char_o    = out_char_q;
  assign line_length_o = line_length_q;
  assign last_o        = last_q;

endmodule

FILE: src/leu_checker.sv
// ----------------------------------------------------------------------------
// Line editor checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "line_editor_with_echo_unit_assert.svh"

module leu_checker import leu_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] out_kind_o,
  input logic [6:0] out_char_o,
  input logic [7:0] line_length_o,
  input logic       last_o
);

  // a read gives exactly one beat
  `LEU_ASSERT_IMP(a_read_last, clk_i, rst_ni, out_valid_o && (out_kind_o == OUT_READ), last_o, "read beat not last")

  // completion ends the item and carries no character
  `LEU_ASSERT_IMP(a_done_last, clk_i, rst_ni, out_valid_o && (out_kind_o == OUT_DONE), last_o && (out_char_o == 7'd0), "bad completion beat")

  // only a completion carries a length
  `LEU_ASSERT_IMP(a_len_zero, clk_i, rst_ni, out_valid_o && (out_kind_o != OUT_DONE), line_length_o == 8'd0, "length on non-completion beat")

  // stalled result beat holds
  `LEU_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_char_o), "stalled beat dropped")

endmodule

bind line_editor_with_echo_unit leu_checker u_leu_checker (.*);

FILE: tb/line_editor_with_echo_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line editor echo checker
// Watches the register port and both channels, works out the echo,
// completion and read beats of every accepted item, and compares the
// result beats with them in order, field by field.
// ----------------------------------------------------------------------------
module line_editor_with_echo_checker import leu_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [8:0]               max_len_i,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     kind_i,
  input  logic [7:0]               keycode_i,
  input  logic [7:0]               read_index_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic [1:0]               out_kind_i,
  input  logic [6:0]               out_char_i,
  input  logic [7:0]               line_length_i,
  input  logic                     last_i,
  output int unsigned              fail_count_o,
  output int unsigned              beats_due_o,
  output logic [LEU_BUF_DEPTH-1:0] stored_o
);

  typedef struct packed {
    out_kind_e  kind;
    logic [6:0] ch;
    logic [7:0] len;
    logic       last;
  } echo_beat_t;

  // expected beats, oldest first
  echo_beat_t               beats_due_q[$];
  // shadow of the line store and edit state
  logic [6:0]               line_mem [LEU_BUF_DEPTH];
  logic [LEU_BUF_DEPTH-1:0] written;
  logic [7:0]               edit_pos;
  logic [8:0]               max_len_q;
  int unsigned              fails;

  // longest line: buffer size less one, size clamped to 2..256
  function automatic int unsigned line_limit(input logic [8:0] n);
    int unsigned m;
    m = n;
    if (m > LEU_BUF_DEPTH) m = LEU_BUF_DEPTH;
    if (m > 256) m = 256;
    if (m < 2) m = 2;
    return m - 1;
  endfunction

  function automatic void add_beat(input out_kind_e kind, input logic [6:0] ch,
                                   input logic [7:0] len);
    echo_beat_t b;
    b.kind = kind;
    b.ch   = ch;
    b.len  = len;
    b.last = 1'b0;
    beats_due_q.push_back(b);
  endfunction

  // edit the shadow line for one item and queue the beats it causes
  function automatic void predict_item(input logic kind, input logic [7:0] code,
                                       input logic [7:0] idx);
    int unsigned lim;
    int unsigned first;
    logic [6:0]  c;
    logic        line_end;
    echo_beat_t  tail;
    lim      = line_limit(max_len_q);
    first    = beats_due_q.size();
    c        = code[6:0];
    line_end = 1'b0;
    if (kind == KIND_READ) begin
      add_beat(OUT_READ, line_mem[idx], 8'd0);
    end else begin
      if (c == KEY_BS) begin
        // nothing to erase at the start of the line
        if (edit_pos != 8'd0) begin
          edit_pos = edit_pos - 8'd1;
          add_beat(OUT_ECHO, KEY_BS, 8'd0);
        end
      end else if (c == KEY_TAB) begin
        // spaces while the line has room, leaving a slot for completion
        for (int j = 0; j < LEU_TAB_WIDTH; j++) begin
          if (beats_due_q.size() - first < LEU_MAX_RESULTS - 1 && edit_pos < lim) begin
            line_mem[edit_pos] = CHAR_SPACE;
            written[edit_pos]  = 1'b1;
            edit_pos           = edit_pos + 8'd1;
            add_beat(OUT_ECHO, CHAR_SPACE, 8'd0);
          end
        end
      end else if (c == KEY_CR || c == KEY_LF) begin
        add_beat(OUT_ECHO, KEY_LF, 8'd0);
        line_end = 1'b1;
      end else begin
        line_mem[edit_pos] = c;
        written[edit_pos]  = 1'b1;
        edit_pos           = edit_pos + 8'd1;
        add_beat(OUT_ECHO, c, 8'd0);
      end
      // line ended, full, or limit lowered below the position
      if (line_end || edit_pos >= lim) begin
        add_beat(OUT_DONE, 7'd0, edit_pos);
        edit_pos = 8'd0;
      end
    end
    if (beats_due_q.size() > first) begin
      tail      = beats_due_q.pop_back();
      tail.last = 1'b1;
      beats_due_q.push_back(tail);
    end
  endfunction

  // register writes, result compare, then prediction of the new item
  always @(posedge clk_i or negedge rst_ni) begin
    echo_beat_t got;
    echo_beat_t want;
    logic       bad;
    if (!rst_ni) begin
      beats_due_q.delete();
      written      = '0;
      edit_pos     = 8'd0;
      max_len_q    = 9'd256;
      fails        = 0;
      fail_count_o <= 0;
      beats_due_o  <= 0;
      stored_o     <= '0;
    end else begin
      if (cfg_we_i) max_len_q = max_len_i;
      if (out_valid_i && out_ready_i) begin
        got.kind = out_kind_e'(out_kind_i);
        got.ch   = out_char_i;
        got.len  = line_length_i;
        got.last = last_i;
        if (beats_due_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected beat kind=%0d char=%02h len=%0d last=%0b",
                     $time, got.kind, got.ch, got.len, got.last);
        end else begin
          want = beats_due_q.pop_front();
          bad  = (got.kind !== want.kind) || (got.ch !== want.ch) ||
                 (got.len !== want.len) || (got.last !== want.last);
          if (bad) begin
            fails++;
            if (fails <= 10)
              $display("%0t: beat mismatch exp kind=%0d char=%02h len=%0d last=%0b, got kind=%0d char=%02h len=%0d last=%0b",
                       $time, want.kind, want.ch, want.len, want.last,
                       got.kind, got.ch, got.len, got.last);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_item(kind_i, keycode_i, read_index_i);
      fail_count_o <= fails;
      beats_due_o  <= beats_due_q.size();
      stored_o     <= written;
    end
  end

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Line editor testbench
// Drives keycodes and reads into the line editor, with directed edge cases
// first and then random lines over several line limits, with random idling
// on both channels and one long output hold-off. The checker beside the
// block predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb;
  import leu_pkg::*;

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       cfg_we_i     = 1'b0;
  logic [8:0] max_len_i    = 9'd0;
  logic       in_valid_i   = 1'b0;
  logic       kind_i       = KIND_KEY;
  logic [7:0] keycode_i    = 8'd0;
  logic [7:0] read_index_i = 8'd0;
  logic       out_ready_i  = 1'b0;

  logic       in_ready_o;
  logic       out_valid_o;
  logic [1:0] out_kind_o;
  logic [6:0] out_char_o;
  logic [7:0] line_length_o;
  logic       last_o;

  int unsigned              fail_count;
  int unsigned              beats_due;
  logic [LEU_BUF_DEPTH-1:0] stored;

  // no idling at all once set; each increment asks for one long hold-off
  bit          steady   = 1'b0;
  int unsigned hold_req = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  line_editor_with_echo_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .max_len_i    (max_len_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .keycode_i    (keycode_i),
    .read_index_i (read_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .out_char_o   (out_char_o),
    .line_length_o(line_length_o),
    .last_o       (last_o)
  );

  line_editor_with_echo_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .max_len_i    (max_len_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .kind_i       (kind_i),
    .keycode_i    (keycode_i),
    .read_index_i (read_index_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_i   (out_kind_o),
    .out_char_i   (out_char_o),
    .line_length_i(line_length_o),
    .last_i       (last_o),
    .fail_count_o (fail_count),
    .beats_due_o  (beats_due),
    .stored_o     (stored)
  );

  // offer one beat and hold it until taken, then maybe idle
  task automatic send_item(input logic kind, input logic [7:0] code,
                           input logic [7:0] idx);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    keycode_i    <= code;
    read_index_i <= idx;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (!steady && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic key(input logic [7:0] code);
    send_item(KIND_KEY, code, 8'($urandom_range(0, 255)));
  endtask

  // read only characters that were written at some point
  task automatic read_at(input logic [7:0] idx);
    int unsigned tries;
    tries = 0;
    while (tries < LEU_BUF_DEPTH && stored[idx] !== 1'b1) begin
      idx = idx - 8'd1;
      tries++;
    end
    if (stored[idx] === 1'b1) send_item(KIND_READ, 8'($urandom_range(0, 255)), idx);
    else key(8'h2E);
  endtask

  // wait until every expected beat is in, then for the block to go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beats_due != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_max_len(input logic [8:0] n);
    cfg_we_i  <= 1'b1;
    max_len_i <= n;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
  endtask

  // mostly text with edits; raw bytes keep every code reachable
  task automatic random_item(input bit no_breaks);
    int unsigned roll;
    logic [7:0]  code;
    roll = $urandom_range(0, 99);
    code = 8'($urandom_range(0, 255));
    if (roll < 10) begin
      read_at(8'($urandom_range(0, 255)));
    end else begin
      if (roll < 55)      code[6:0] = 7'($urandom_range(32, 126));
      else if (roll < 65) code[6:0] = KEY_BS;
      else if (roll < 80) code[6:0] = KEY_TAB;
      else if (roll < 87)
        code[6:0] = no_breaks ? CHAR_SPACE : ($urandom_range(0, 1) ? KEY_CR : KEY_LF);
      key(code);
    end
  endtask

  task automatic random_run(input int unsigned count, input bit no_breaks);
    repeat (count) random_item(no_breaks);
  endtask

  // result side: random stalls, ready stretches, and the long hold-off
  initial begin : sink
    int unsigned hold_seen;
    hold_seen = 0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        out_ready_i <= 1'b0;
        repeat (120) @(posedge clk_i);
      end else if (!steady && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edits at the default size
    key({1'b0, KEY_BS});        // empty line: no beat at all
    key({1'b1, KEY_BS});        // top bit dropped, still backspace
    key(8'h41);
    key(8'hFF);                 // stored as 7F
    key(8'h00);
    key(8'h1B);                 // control codes are stored too
    key({1'b0, KEY_BS});
    key({1'b0, KEY_TAB});
    read_at(8'd0);
    read_at(8'd3);
    key({1'b0, KEY_CR});
    key({1'b1, KEY_LF});        // empty line
    read_at(8'd1);
    read_at(8'd2);
    settle();

    // tab that exactly fills the line: four spaces and completion
    set_max_len(9'd5);
    key({1'b0, KEY_TAB});
    key(8'h78);
    key(8'h79);
    settle();

    // limit lowered below the current position
    set_max_len(9'd2);
    key({1'b0, KEY_BS});
    key(8'h7A);
    key({1'b1, KEY_TAB});
    settle();

    // out-of-range sizes clamp
    set_max_len(9'd0);
    key(8'h71);
    settle();
    set_max_len(9'd1);
    key({1'b0, KEY_CR});
    settle();
    set_max_len(9'h1FF);
    read_at(8'd0);
    settle();

    // long lines that end at the limit, one slot below the top of the store
    set_max_len(9'd256);
    random_run(170, 1'b1);
    settle();

    // short lines; the first keys see a limit below the position
    set_max_len(9'($urandom_range(2, 20)));
    random_run(70, 1'b0);
    settle();

    // full size with the output held off while items keep coming
    set_max_len(9'h1FF);
    random_run(30, 1'b0);
    hold_req <= hold_req + 1;
    random_run(40, 1'b0);
    settle();

    set_max_len(9'd0);
    random_run(25, 1'b0);
    settle();

    // closing stretch without idling
    set_max_len(9'($urandom_range(5, 60)));
    steady <= 1'b1;
    random_run(60, 1'b0);
    settle();

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+src
src/leu_pkg.sv
src/leu_ram.sv
src/line_editor_with_echo_unit.sv
src/leu_checker.sv
tb/line_editor_with_echo_checker.sv
tb/tb.sv
